// ----- rtl/core/lhpf_pkg.sv -----
// Package for the lane histogram peak finder: register indexes, reset values,
// field widths and the result word type. Used by the top level and lhpf_out_fifo.
`default_nettype none

package lhpf_pkg;

  // Default frame limits (top-level parameter defaults)
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 256;

  // Configuration port
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAY_THRESHOLD = 3'd0,
    REG_ROI_TOP        = 3'd1,
    REG_ROI_BOTTOM     = 3'd2,
    REG_LEFT_END       = 3'd3,
    REG_RIGHT_START    = 3'd4,
    REG_FRAME_CENTER   = 3'd5,
    REG_IMAGE_WIDTH    = 3'd6,
    REG_IMAGE_HEIGHT   = 3'd7
  } lhpf_reg_t;

  // Register reset values
  localparam logic [7:0] RST_GRAY_THRESHOLD = 8'd200;
  localparam logic [7:0] RST_ROI_TOP        = 8'd140;
  localparam logic [7:0] RST_ROI_BOTTOM     = 8'd239;
  localparam logic [8:0] RST_LEFT_END       = 9'd149;
  localparam logic [8:0] RST_RIGHT_START    = 9'd250;
  localparam logic [8:0] RST_FRAME_CENTER   = 9'd188;
  localparam logic [9:0] RST_IMAGE_WIDTH    = 10'd400;
  localparam logic [8:0] RST_IMAGE_HEIGHT   = 9'd240;

  // Field widths
  localparam int GRAY_W      = 8;
  localparam int POS_W       = 9;
  localparam int OFF_W       = 10;
  localparam int COUNT_W     = 9;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // One result word; last field in the lowest bits
  typedef struct packed {
    logic signed [OFF_W-1:0] offset;
    logic [POS_W-1:0]        lane_center;
    logic [POS_W-1:0]        right_pos;
    logic [POS_W-1:0]        left_pos;
  } lhpf_result_t;

  localparam int RESULT_W = $bits(lhpf_result_t);

  // Push request from the result stage into the output queue
  typedef struct packed {
    logic         valid;
    lhpf_result_t result;
  } lhpf_push_t;

endpackage

`default_nettype wire

// ----- rtl/core/lane_histogram_peak_finder_unit.sv -----
// Lane histogram peak finder, top level: pixel pipeline, column count RAM,
// peak tracking and result math. Depends on lhpf_pkg, lhpf_ram, lhpf_out_fifo.
//
//  channel | dir | word                                  | handshake
//  s_*     | in  | tdata: gray_pixel; tuser: edge_flag   | tvalid/tready
//  m_*     | out | tdata: left, right, center, offset    | tvalid/tready
//  cfg_*   | in  | cfg_index, cfg_data                   | cfg_wr_en, no wait
//
// One pixel per clock while s_tready is high. A pixel enters the input stage
// (position counters and RAM read), updates its column count and the peaks in
// the next cycle, and a frame's result lands in a four-word queue in the cycle
// after that, through the s2_end register; m_tvalid rises once it is queued.
// s_tready drops only when the queue plus the results in flight would fill it.
// The column count RAM has no clearing pass: the first window row overwrites
// every count.
`default_nettype none

module lane_histogram_peak_finder_unit #(
  parameter int MAX_WIDTH  = lhpf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lhpf_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  input  wire logic [lhpf_pkg::IN_TDATA_W-1:0]    s_tdata,   // gray_pixel
  input  wire logic [lhpf_pkg::IN_TUSER_W-1:0]    s_tuser,   // edge_flag
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  output      logic [lhpf_pkg::OUT_TDATA_W-1:0]   m_tdata,   // left_pos[8:0],
                                                             // right_pos[17:9],
                                                             // lane_center[26:18],
                                                             // offset[36:27]
  input  wire logic                               cfg_wr_en,
  input  wire logic [lhpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lhpf_pkg::CFG_W-1:0]         cfg_data
);

  import lhpf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CWE = $clog2(MAX_WIDTH + 1);
  localparam int XW  = (CWE > CFG_W) ? CWE : CFG_W;
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int RWE = $clog2(MAX_HEIGHT + 1);
  localparam int YW  = (RWE > 9) ? RWE : 9;
  localparam int PW  = (CW > OFF_W) ? CW : OFF_W;

  typedef struct packed {
    logic [CW-1:0] col;
    logic          win;
    logic          first;
    logic          last;
    logic          left;
    logic          right;
    logic          mark;
    logic          fstart;
    logic          fend;
  } s1_info_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [7:0] gray_threshold, roi_top, roi_bottom;
  logic [8:0] left_end, right_start, frame_center, image_height;
  logic [9:0] image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_threshold <= RST_GRAY_THRESHOLD;
      roi_top        <= RST_ROI_TOP;
      roi_bottom     <= RST_ROI_BOTTOM;
      left_end       <= RST_LEFT_END;
      right_start    <= RST_RIGHT_START;
      frame_center   <= RST_FRAME_CENTER;
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
    end else if (cfg_wr_en) begin
      unique case (lhpf_reg_t'(cfg_index))
        REG_GRAY_THRESHOLD: gray_threshold <= cfg_data[7:0];
        REG_ROI_TOP:        roi_top        <= cfg_data[7:0];
        REG_ROI_BOTTOM:     roi_bottom     <= cfg_data[7:0];
        REG_LEFT_END:       left_end       <= cfg_data[8:0];
        REG_RIGHT_START:    right_start    <= cfg_data[8:0];
        REG_FRAME_CENTER:   frame_center   <= cfg_data[8:0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[9:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[8:0];
        default:            gray_threshold <= gray_threshold;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: raster position, window and region flags
  logic [CW-1:0] col_reg, col_next, col_eff;
  logic [RW-1:0] row_reg, row_next;
  logic [XW-1:0] img_w, w_lim, col_inc;
  logic [YW-1:0] img_h, h_lim, row_tmp, row_eff, row_inc;
  logic          col_wrap, last_col, last_row_img, accept;
  logic          in_win, in_left, in_right, marked;
  s1_info_t      s1_in, s1;
  logic          s1_valid;

  assign accept = s_tvalid && s_tready;

  // zero counts as one, large values saturate
  assign img_w = XW'(image_width);
  assign img_h = YW'(image_height);
  assign w_lim = (img_w == '0) ? XW'(1) : ((img_w > XW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : img_w);
  assign h_lim = (img_h == '0) ? YW'(1) : ((img_h > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : img_h);

  // counters wrap at once if the frame size shrank
  assign col_wrap = (XW'(col_reg) >= w_lim);
  assign col_eff  = col_wrap ? '0 : col_reg;
  assign row_tmp  = col_wrap ? (YW'(row_reg) + YW'(1)) : YW'(row_reg);
  assign row_eff  = (row_tmp >= h_lim) ? '0 : row_tmp;

  assign col_inc      = XW'(col_eff) + XW'(1);
  assign row_inc      = row_eff + YW'(1);
  assign last_col     = (col_inc >= w_lim);
  assign last_row_img = (row_inc >= h_lim);

  always_comb begin
    if (last_col) begin
      col_next = '0;
      row_next = last_row_img ? '0 : row_inc[RW-1:0];
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = row_eff[RW-1:0];
    end
  end

  assign in_win   = (row_eff >= YW'(roi_top)) && (row_eff <= YW'(roi_bottom));
  assign in_left  = (PW'(col_eff) <= PW'(left_end));
  assign in_right = (PW'(col_eff) >= PW'(right_start));
  assign marked   = (s_tdata[GRAY_W-1:0] >= gray_threshold) || s_tuser[0];

  always_comb begin
    s1_in.col    = col_eff;
    s1_in.win    = in_win;
    s1_in.first  = (row_eff == YW'(roi_top));
    s1_in.last   = (row_eff == YW'(roi_bottom));
    s1_in.left   = in_left;
    s1_in.right  = in_right;
    s1_in.mark   = marked;
    s1_in.fstart = (col_eff == '0) && (row_eff == '0);
    s1_in.fend   = last_col && last_row_img;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_reg  <= '0;
      row_reg  <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col_reg <= col_next;
        row_reg <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_in;
    end
  end

  // ---------------------------------------------------------------------
  // Column count RAM, read in the input stage, written back in stage 1
  logic [COUNT_W-1:0] rd_data, cnt_base, cnt_new, byp_data;
  logic               wr_en, byp_hit;

  lhpf_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_WIDTH)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1.col),
    .wr_data (cnt_new),
    .rd_addr (col_eff),
    .rd_data (rd_data)
  );

  // first window row starts from zero; saturating increment
  assign cnt_base = s1.first ? '0 : (byp_hit ? byp_data : rd_data);
  assign cnt_new  = (s1.mark && (cnt_base != COUNT_MAX)) ? cnt_base + COUNT_W'(1) : cnt_base;
  assign wr_en    = s1_valid && s1.win;

  // bypass for a read that races the write of the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= accept && wr_en && (s1.col == col_eff);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= cnt_new;
  end

  // ---------------------------------------------------------------------
  // Peak tracking on the last window row (first maximum wins)
  logic [COUNT_W-1:0] left_best_count, right_best_count;
  logic [COUNT_W-1:0] left_best_count_next, right_best_count_next;
  logic [PW-1:0]      left_best_column, right_best_column;
  logic [PW-1:0]      left_best_column_next, right_best_column_next;

  always_comb begin
    left_best_count_next   = left_best_count;
    left_best_column_next  = left_best_column;
    right_best_count_next  = right_best_count;
    right_best_column_next = right_best_column;
    if (s1_valid) begin
      if (s1.fstart) begin
        left_best_count_next   = '0;
        left_best_column_next  = '0;
        right_best_count_next  = '0;
        right_best_column_next = PW'(right_start);
      end
      if (s1.win && s1.last) begin
        if (s1.left && (cnt_new > left_best_count_next)) begin
          left_best_count_next  = cnt_new;
          left_best_column_next = PW'(s1.col);
        end
        if (s1.right && (cnt_new > right_best_count_next)) begin
          right_best_count_next  = cnt_new;
          right_best_column_next = PW'(s1.col);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_best_count   <= '0;
      left_best_column  <= '0;
      right_best_count  <= '0;
      right_best_column <= '0;
    end else begin
      left_best_count   <= left_best_count_next;
      left_best_column  <= left_best_column_next;
      right_best_count  <= right_best_count_next;
      right_best_column <= right_best_column_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result stage: center and offset from the settled peaks
  logic                 s2_end;
  logic signed [PW:0]   l_s, r_s, diff, half, center, off;
  lhpf_push_t           push;
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W:0]   pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_end <= 1'b0;
    end else begin
      s2_end <= s1_valid && s1.fend;
    end
  end

  // halving truncates toward zero
  assign l_s    = $signed({1'b0, left_best_column});
  assign r_s    = $signed({1'b0, right_best_column});
  assign diff   = r_s - l_s;
  assign half   = (diff + ((diff < 0) ? (PW+1)'(1) : (PW+1)'(0))) >>> 1;
  assign center = l_s + half;
  assign off    = center - $signed({1'b0, PW'(frame_center)});

  always_comb begin
    push.valid              = s2_end;
    push.result.left_pos    = left_best_column[POS_W-1:0];
    push.result.right_pos   = right_best_column[POS_W-1:0];
    push.result.lane_center = center[POS_W-1:0];
    push.result.offset      = off[OFF_W-1:0];
  end

  lhpf_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .count    (q_count),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // hold off input when queued plus in-flight results could overflow
  assign pending  = (OUT_CNT_W+1)'(q_count)
                  + (OUT_CNT_W+1)'(s1_valid && s1.fend)
                  + (OUT_CNT_W+1)'(s2_end);
  assign s_tready = (pending < (OUT_CNT_W+1)'(OUT_DEPTH));

  // ---------------------------------------------------------------------
  // Assertions
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue over its depth");

  a_end_to_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.fend) |=> s2_end)
    else $error("frame end did not reach the result stage");

  a_bypass_live: assert property (@(posedge clk) disable iff (rst)
    byp_hit |-> s1_valid)
    else $error("count bypass set without a pixel in stage 1");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (push.valid && (q_count == OUT_CNT_W'(OUT_DEPTH))) |-> (m_tvalid && m_tready))
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire

// ----- rtl/core/lhpf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No reset on the storage. Depends on nothing.
`default_nettype none

module lhpf_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/lhpf_out_fifo.sv -----
// Small result queue feeding the master-side stream of the peak finder.
// Depends on lhpf_pkg (result word and push struct).
`default_nettype none

module lhpf_out_fifo #(
  parameter int DEPTH = lhpf_pkg::OUT_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lhpf_pkg::lhpf_push_t                push,
  output      logic [$clog2(DEPTH+1)-1:0]          count,
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  output      logic [lhpf_pkg::OUT_TDATA_W-1:0]    m_tdata  // left_pos, right_pos,
                                                            // lane_center, offset, pad
);

  import lhpf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lhpf_result_t     entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, entry[rd_ptr]};

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[wr_ptr] <= push.result;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push.valid, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire
